>>> rtl/core/vertex_transform_perspective_divide_assert.svh
// Assertion macros shared by the checkers of the vertex transform block.
// Needs nothing else; include once per file that asserts.
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_ASSERT_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define VTPD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked in reset too
`define VTPD_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/vtpd_pkg.sv
// Shared types and constants of the vertex transform with perspective divide.
// Depends on nothing.
`timescale 1ns / 1ps

package vtpd_pkg;

   localparam int DIM       = 4;
   localparam int IN_W      = 32;
   localparam int COEF_W    = 16;
   localparam int ROW_W     = 64;
   localparam int PROD_W    = 48;
   localparam int SUM_W     = 50;
   localparam int QW        = 33;
   localparam int LANE_LAT  = 2;
   localparam int DIV_LAT   = QW + 2;
   localparam int LATENCY   = LANE_LAT + DIV_LAT + 1;

   localparam logic signed [IN_W-1:0] ONE_Q16 = 32'sh0001_0000;
   localparam logic signed [IN_W-1:0] Q16_MAX = 32'sh7fff_ffff;
   localparam logic signed [IN_W-1:0] Q16_MIN = 32'sh8000_0000;

   localparam logic [ROW_W-1:0] ROW_ZERO_RESET  = 64'h0000_0000_0000_1000;
   localparam logic [ROW_W-1:0] ROW_ONE_RESET   = 64'h0000_0000_1000_0000;
   localparam logic [ROW_W-1:0] ROW_TWO_RESET   = 64'h0000_1000_0000_0000;
   localparam logic [ROW_W-1:0] ROW_THREE_RESET = 64'h1000_0000_0000_0000;

   typedef enum logic [1:0] {
      CSR_ROW_ZERO,
      CSR_ROW_ONE,
      CSR_ROW_TWO,
      CSR_ROW_THREE
   } csr_index_type;

   typedef struct packed {
      logic signed [IN_W-1:0] value;
      logic                   sat;
   } clamp_type;

   typedef struct packed {
      logic [DIM-1:0][IN_W-1:0] value;
      logic                     sat;
      logic                     w_zero;
      logic                     w_one;
   } merge_tag_type;

endpackage

>>> rtl/core/vtpd_lane.sv
// One matrix row times the vertex: four products, then rounded row sum.
// Depends on vtpd_pkg.
`timescale 1ns / 1ps

module vtpd_lane #(
   parameter int COEF_FRAC_BITS = 12,
   parameter int TW             = 38
) (
   input  logic                                  clock,
   input  logic [vtpd_pkg::ROW_W-1:0]            row,
   input  logic signed [vtpd_pkg::IN_W-1:0]      vec [vtpd_pkg::DIM],
   output logic signed [TW-1:0]                  t_out
);

   logic signed [vtpd_pkg::COEF_W-1:0] coef [vtpd_pkg::DIM];
   logic signed [vtpd_pkg::PROD_W-1:0] prod_in [vtpd_pkg::DIM];
   logic signed [vtpd_pkg::PROD_W-1:0] prod_ff [vtpd_pkg::DIM];
   logic signed [vtpd_pkg::SUM_W-1:0]  sum;
   logic signed [TW-1:0]               t_in;
   logic signed [TW-1:0]               t_ff;

   always_comb begin
      for (int j = 0; j < vtpd_pkg::DIM; j++) begin
         coef[j]    = row[vtpd_pkg::COEF_W*j +: vtpd_pkg::COEF_W];
         prod_in[j] = coef[j] * vec[j];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      t_ff    <= t_in;
   end

   always_comb begin
      sum = vtpd_pkg::SUM_W'(prod_ff[0]) + vtpd_pkg::SUM_W'(prod_ff[1])
          + vtpd_pkg::SUM_W'(prod_ff[2]) + vtpd_pkg::SUM_W'(prod_ff[3])
          + (vtpd_pkg::SUM_W'(1) << (COEF_FRAC_BITS - 1));
      t_in = TW'(sum >>> COEF_FRAC_BITS);
   end

   assign t_out = t_ff;

endmodule

>>> rtl/core/vtpd_div.sv
// Pipelined restoring divider: (num * 1.0) / den, one quotient bit a stage,
// clamped to Q16.16. Depends on vtpd_pkg.
`timescale 1ns / 1ps

module vtpd_div #(
   parameter int TW = 38
) (
   input  logic                      clock,
   input  logic signed [TW-1:0]      num,
   input  logic signed [TW-1:0]      den,
   output vtpd_pkg::clamp_type       result
);

   localparam int QW = vtpd_pkg::QW;

   logic [TW-1:0]  rem_ff  [QW+1];
   logic [TW-1:0]  nmag_ff [QW+1];
   logic [TW-1:0]  dmag_ff [QW+1];
   logic [QW-1:0]  quo_ff  [QW+1];
   logic           neg_ff  [QW+1];
   logic           ovf_ff  [QW+1];

   logic [TW-1:0]  nabs;
   logic [TW-1:0]  dabs;
   vtpd_pkg::clamp_type result_in;
   vtpd_pkg::clamp_type result_ff;

   always_comb begin
      nabs = num[TW-1] ? TW'(-num) : TW'(num);
      dabs = den[TW-1] ? TW'(-den) : TW'(den);
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= nabs >> 17;
      nmag_ff[0] <= nabs;
      dmag_ff[0] <= dabs;
      quo_ff[0]  <= '0;
      neg_ff[0]  <= num[TW-1] ^ den[TW-1];
      ovf_ff[0]  <= (nabs >> 17) >= dabs;
   end

   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int B = QW - 1 - k;
      logic          nbit;
      logic [TW:0]   trial;
      logic          take;

      if (B >= 16) begin : g_bit
         assign nbit = nmag_ff[k][B-16];
      end else begin : g_zero
         assign nbit = 1'b0;
      end

      always_comb begin
         trial = {rem_ff[k], nbit};
         take  = trial >= {1'b0, dmag_ff[k]};
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= take ? TW'(trial - {1'b0, dmag_ff[k]}) : TW'(trial);
         quo_ff[k+1]  <= quo_ff[k] | (QW'(take) << B);
         nmag_ff[k+1] <= nmag_ff[k];
         dmag_ff[k+1] <= dmag_ff[k];
         neg_ff[k+1]  <= neg_ff[k];
         ovf_ff[k+1]  <= ovf_ff[k];
      end
   end

   always_comb begin
      result_in.sat   = 1'b0;
      result_in.value = quo_ff[QW][31:0];
      if (ovf_ff[QW]) begin
         result_in.sat   = 1'b1;
         result_in.value = neg_ff[QW] ? vtpd_pkg::Q16_MIN : vtpd_pkg::Q16_MAX;
      end else if (!neg_ff[QW]) begin
         if (quo_ff[QW][32] || quo_ff[QW][31]) begin
            result_in.sat   = 1'b1;
            result_in.value = vtpd_pkg::Q16_MAX;
         end
      end else begin
         if (quo_ff[QW][32] || (quo_ff[QW][31] && (|quo_ff[QW][30:0]))) begin
            result_in.sat   = 1'b1;
            result_in.value = vtpd_pkg::Q16_MIN;
         end else begin
            result_in.value = 32'(QW'(0) - quo_ff[QW]);
         end
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

>>> rtl/core/vtpd_merge.sv
// Merge stage: classify w, clamp the undivided sums, hold them beside the
// dividers and pick the final word. Depends on vtpd_pkg.
`timescale 1ns / 1ps

module vtpd_merge #(
   parameter int TW = 38
) (
   input  logic                                clock,
   input  logic signed [TW-1:0]                t_in [vtpd_pkg::DIM],
   input  vtpd_pkg::clamp_type                 div_in [vtpd_pkg::DIM-1],
   output logic signed [vtpd_pkg::IN_W-1:0]    out_x,
   output logic signed [vtpd_pkg::IN_W-1:0]    out_y,
   output logic signed [vtpd_pkg::IN_W-1:0]    out_z,
   output logic signed [vtpd_pkg::IN_W-1:0]    out_w,
   output logic                                w_zero,
   output logic                                saturated
);

   localparam int DL = vtpd_pkg::DIV_LAT;
   localparam logic signed [TW-1:0] MAXV = {{(TW-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [TW-1:0] MINV = {{(TW-31){1'b1}}, 31'd0};

   vtpd_pkg::merge_tag_type tag_in;
   vtpd_pkg::merge_tag_type tag_ff [DL];
   vtpd_pkg::merge_tag_type tag;

   logic                              div_sel;
   logic signed [vtpd_pkg::IN_W-1:0]  val_in [vtpd_pkg::DIM];
   logic signed [vtpd_pkg::IN_W-1:0]  val_ff [vtpd_pkg::DIM];
   logic                              w_zero_in, w_zero_ff;
   logic                              sat_in, sat_ff;

   always_comb begin
      tag_in.sat = 1'b0;
      for (int i = 0; i < vtpd_pkg::DIM; i++) begin
         if (t_in[i] > MAXV) begin
            tag_in.value[i] = vtpd_pkg::Q16_MAX;
            tag_in.sat      = 1'b1;
         end else if (t_in[i] < MINV) begin
            tag_in.value[i] = vtpd_pkg::Q16_MIN;
            tag_in.sat      = 1'b1;
         end else begin
            tag_in.value[i] = t_in[i][31:0];
         end
      end
      tag_in.w_zero = (t_in[3] == '0);
      tag_in.w_one  = (t_in[3] == TW'(vtpd_pkg::ONE_Q16));
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= tag_in;
      for (int k = 1; k < DL; k++) begin
         tag_ff[k] <= tag_ff[k-1];
      end
   end

   always_comb begin
      tag     = tag_ff[DL-1];
      div_sel = !tag.w_zero && !tag.w_one;
      for (int i = 0; i < vtpd_pkg::DIM - 1; i++) begin
         val_in[i] = div_sel ? div_in[i].value : tag.value[i];
      end
      val_in[3] = div_sel ? vtpd_pkg::ONE_Q16 : tag.value[3];
      sat_in    = div_sel ? (div_in[0].sat | div_in[1].sat | div_in[2].sat) : tag.sat;
      w_zero_in = tag.w_zero;
   end

   always_ff @(posedge clock) begin
      val_ff    <= val_in;
      sat_ff    <= sat_in;
      w_zero_ff <= w_zero_in;
   end

   assign out_x     = val_ff[0];
   assign out_y     = val_ff[1];
   assign out_z     = val_ff[2];
   assign out_w     = val_ff[3];
   assign w_zero    = w_zero_ff;
   assign saturated = sat_ff;

endmodule

>>> rtl/core/vertex_transform_perspective_divide.sv
// Homogeneous 4x4 vertex transform with perspective divide.
// Usage:
//   Input: drive req_in_x/y/z/w (signed Q16.16) and pulse start; the word
//   is taken at any edge with start high and busy low. busy is high only in
//   the cycle after a reset edge, so one vertex may enter every cycle.
//   Matrix: write rows through csr_we/csr_index/csr_wdata (four signed
//   Q4.12 coefficients a row, column j in bits 16j+15..16j) while idle.
//   Output: each result is on rsp_out_* with rsp_w_zero and rsp_saturated
//   for exactly one cycle, flagged by rsp_valid.
//   Throughput is one vertex a cycle while busy is low: four row lanes of
//   four multipliers, then three divider pipelines of 33 single-bit stages.
//   Reset loads the identity matrix and empties the result pipeline.
//   The receiver cannot stall; results are never held back.
// Depends on vtpd_pkg, vtpd_lane, vtpd_div and vtpd_merge.
`timescale 1ns / 1ps

module vertex_transform_perspective_divide #(
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [vtpd_pkg::IN_W-1:0]   req_in_x,
   input  logic signed [vtpd_pkg::IN_W-1:0]   req_in_y,
   input  logic signed [vtpd_pkg::IN_W-1:0]   req_in_z,
   input  logic signed [vtpd_pkg::IN_W-1:0]   req_in_w,
   output logic                               rsp_valid,
   output logic signed [vtpd_pkg::IN_W-1:0]   rsp_out_x,
   output logic signed [vtpd_pkg::IN_W-1:0]   rsp_out_y,
   output logic signed [vtpd_pkg::IN_W-1:0]   rsp_out_z,
   output logic signed [vtpd_pkg::IN_W-1:0]   rsp_out_w,
   output logic                               rsp_w_zero,
   output logic                               rsp_saturated,
   input  logic                               csr_we,
   input  vtpd_pkg::csr_index_type            csr_index,
   input  logic [vtpd_pkg::ROW_W-1:0]         csr_wdata
);

   localparam int TW  = vtpd_pkg::SUM_W - COEF_FRAC_BITS;
   localparam int LAT = vtpd_pkg::LATENCY;

   logic [vtpd_pkg::ROW_W-1:0]        row_ff [vtpd_pkg::DIM];
   logic                              busy_ff;
   logic [LAT-1:0]                    valid_ff;
   logic                              accept;
   logic signed [vtpd_pkg::IN_W-1:0]  vec [vtpd_pkg::DIM];
   logic signed [TW-1:0]              t_lane [vtpd_pkg::DIM];
   vtpd_pkg::clamp_type               div_res [vtpd_pkg::DIM-1];

   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= vtpd_pkg::ROW_ZERO_RESET;
         row_ff[1] <= vtpd_pkg::ROW_ONE_RESET;
         row_ff[2] <= vtpd_pkg::ROW_TWO_RESET;
         row_ff[3] <= vtpd_pkg::ROW_THREE_RESET;
         busy_ff   <= 1'b1;
         valid_ff  <= '0;
      end else begin
         busy_ff  <= 1'b0;
         valid_ff <= {valid_ff[LAT-2:0], accept};
         if (csr_we) begin
            case (csr_index)
               vtpd_pkg::CSR_ROW_ZERO:  row_ff[0] <= csr_wdata;
               vtpd_pkg::CSR_ROW_ONE:   row_ff[1] <= csr_wdata;
               vtpd_pkg::CSR_ROW_TWO:   row_ff[2] <= csr_wdata;
               vtpd_pkg::CSR_ROW_THREE: row_ff[3] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      vec[0] = req_in_x;
      vec[1] = req_in_y;
      vec[2] = req_in_z;
      vec[3] = req_in_w;
   end

   for (genvar i = 0; i < vtpd_pkg::DIM; i++) begin : g_lane
      vtpd_lane #(
         .COEF_FRAC_BITS (COEF_FRAC_BITS),
         .TW             (TW)
      ) u_lane (
         .clock (clock),
         .row   (row_ff[i]),
         .vec   (vec),
         .t_out (t_lane[i])
      );
   end

   for (genvar i = 0; i < vtpd_pkg::DIM - 1; i++) begin : g_div
      vtpd_div #(
         .TW (TW)
      ) u_div (
         .clock  (clock),
         .num    (t_lane[i]),
         .den    (t_lane[3]),
         .result (div_res[i])
      );
   end

   vtpd_merge #(
      .TW (TW)
   ) u_merge (
      .clock     (clock),
      .t_in      (t_lane),
      .div_in    (div_res),
      .out_x     (rsp_out_x),
      .out_y     (rsp_out_y),
      .out_z     (rsp_out_z),
      .out_w     (rsp_out_w),
      .w_zero    (rsp_w_zero),
      .saturated (rsp_saturated)
   );

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff[LAT-1];

endmodule

>>> rtl/core/vtpd_checker.sv
// Port-level checks of the vertex transform block, bound to the top level.
// Depends on vtpd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "vertex_transform_perspective_divide_assert.svh"

module vtpd_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               rsp_valid,
   input  logic signed [vtpd_pkg::IN_W-1:0]   rsp_out_x,
   input  logic signed [vtpd_pkg::IN_W-1:0]   rsp_out_y,
   input  logic signed [vtpd_pkg::IN_W-1:0]   rsp_out_z,
   input  logic signed [vtpd_pkg::IN_W-1:0]   rsp_out_w,
   input  logic                               rsp_w_zero,
   input  logic                               rsp_saturated
);

   logic any_extreme;

   assign any_extreme = (rsp_out_x == vtpd_pkg::Q16_MAX) || (rsp_out_x == vtpd_pkg::Q16_MIN)
                     || (rsp_out_y == vtpd_pkg::Q16_MAX) || (rsp_out_y == vtpd_pkg::Q16_MIN)
                     || (rsp_out_z == vtpd_pkg::Q16_MAX) || (rsp_out_z == vtpd_pkg::Q16_MIN)
                     || (rsp_out_w == vtpd_pkg::Q16_MAX) || (rsp_out_w == vtpd_pkg::Q16_MIN);

   `VTPD_ASSERT_NEXT(a_reset_busy, clock, reset, busy, "busy low after reset edge")
   `VTPD_ASSERT_IMP(a_latency, clock, reset, rsp_valid, $past(start && !busy, vtpd_pkg::LATENCY), "result word without matching start")
   `VTPD_ASSERT_IMP(a_wzero_w, clock, reset, rsp_valid && rsp_w_zero, rsp_out_w == '0, "w_zero word with nonzero w")
   `VTPD_ASSERT_IMP(a_w_one, clock, reset, rsp_valid && !rsp_w_zero, rsp_out_w == vtpd_pkg::ONE_Q16, "w not one on a nonzero-w word")
   `VTPD_ASSERT_IMP(a_sat_edge, clock, reset, rsp_valid && rsp_saturated, any_extreme, "saturated word with no clamped component")

endmodule

bind vertex_transform_perspective_divide vtpd_checker u_vtpd_checker (.*);
